// ===== design/priority_round_robin_task_scheduler_unit_defines.svh =====
// Assertion macros for the task scheduler.
`ifndef PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_UNIT_DEFINES_SVH
`define PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PRTS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed");
`define PRTS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed");
`else
`define PRTS_ASSERT_IMP(name, ante, cons)
`define PRTS_ASSERT_NXT(name, ante, cons)
`endif
`endif

// ===== design/prts_pkg.sv =====
// Types and constants shared by the task scheduler modules.
`default_nettype none
package prts_pkg;
  localparam int TASK_SLOTS  = 16;
  localparam int PRIO_LEVELS = 32;
  localparam int TASK_W      = 4;
  localparam int PRIO_W      = 5;
  localparam int CNT_W       = TASK_W + 1;
  localparam int DLY_W       = 16;
  localparam logic [7:0] LOCK_MAX = 8'd254;
  localparam logic [7:0] SLICE_RST = 8'd10;

  localparam logic [3:0] ACT_TICK    = 4'd0;
  localparam logic [3:0] ACT_READY   = 4'd1;
  localparam logic [3:0] ACT_UNREADY = 4'd2;
  localparam logic [3:0] ACT_DELAY   = 4'd3;
  localparam logic [3:0] ACT_WAKE    = 4'd4;
  localparam logic [3:0] ACT_LOCK    = 4'd5;
  localparam logic [3:0] ACT_UNLOCK  = 4'd6;
  localparam logic [3:0] ACT_SCHED   = 4'd7;
  localparam logic [3:0] ACT_SETUP   = 4'd8;
  localparam logic [3:0] ACT_WAIT    = 4'd9;

  localparam logic [1:0] KIND_SWITCH = 2'd0;
  localparam logic [1:0] KIND_TMO    = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  typedef enum logic [2:0] {
    RDY_NONE,
    RDY_HEAD_IF_ABSENT,
    RDY_HEAD_FORCE,
    RDY_TAIL_IF_PRESENT,
    RDY_REMOVE
  } rdy_op_t;

  typedef struct packed {
    rdy_op_t            op;
    logic [TASK_W-1:0]  task_id;
  } rdy_cmd_t;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DWALK  = 7'b0000010,
    S_DRM    = 7'b0000100,
    S_ROT    = 7'b0001000,
    S_SCAN   = 7'b0010000,
    S_SWITCH = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;
endpackage
`default_nettype wire

// ===== design/priority_round_robin_task_scheduler_unit.sv =====
// Priority scheduler with round robin within each priority and a tick-driven delay list.
`default_nettype none
`include "priority_round_robin_task_scheduler_unit_defines.svh"
// One action word at a time. A tick walks the delay list one entry a cycle,
// pausing while a timeout result for a waiting task cannot be emitted, then
// does slice rotation and, when unlocked, a scan of the task slots through
// one priority/order comparator, plus a switch step and a done step.
// Schedule (when unlocked) and unlock-to-zero run the scan, switch and done.
// Wake and set up of a delayed task walk the delay list.
// Result words wait while out_stall is high; no reset sweep is needed.
module priority_round_robin_task_scheduler_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [3:0]  in_action,
  input  wire  [3:0]  in_task_id,
  input  wire  [4:0]  in_task_prio,
  input  wire  [15:0] in_ticks,
  input  wire         in_wait_flag,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_task_ref,
  output logic [7:0]  out_lock_level,
  output logic        out_last,
  input  wire         cfg_wr_en,
  input  wire  [7:0]  cfg_wr_data
);
  import prts_pkg::*;

  state_t             state_r;
  logic [3:0]         act_r;
  logic [TASK_W-1:0]  tid_r;
  logic [PRIO_W-1:0]  prio_r;
  logic [CNT_W-1:0]   idx_r;
  logic [CNT_W-1:0]   wr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [TASK_W-1:0]  best_r;
  logic               best_ok_r;
  logic [PRIO_W-1:0]  bprio_r;

  logic [PRIO_W-1:0]  tprio_r [TASK_SLOTS];
  logic [DLY_W-1:0]   drem_r  [TASK_SLOTS];
  logic [7:0]         slice_r [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] dly_r;
  logic [TASK_SLOTS-1:0] wait_r;
  logic [TASK_W-1:0]  dorder_r [TASK_SLOTS];
  logic [CNT_W-1:0]   dlen_r;
  logic [TASK_W-1:0]  cur_r;
  logic               cur_ok_r;
  logic [7:0]         lock_r;
  logic [7:0]         slen_r;

  logic               out_valid_r;
  logic [1:0]         out_kind_r;
  logic [3:0]         out_task_r;
  logic [7:0]         out_lock_r;
  logic               out_last_r;

  rdy_cmd_t           rdy_cmd;
  logic [TASK_SLOTS-1:0] rdy;
  logic               before_q;

  logic               in_acc;
  logic               tid_ok;
  logic               out_free;
  logic [TASK_W-1:0]  dw_t;
  logic [DLY_W-1:0]   dw_rem;
  logic               dw_end;
  logic               dw_exp;
  logic               dw_go;
  logic [TASK_W-1:0]  scan_t;
  logic               scan_better;
  logic               sw_need;
  logic [7:0]         rot_slice;
  logic [7:0]         unlock_nxt;
  logic               do_setup;
  logic [TASK_W-1:0]  setup_t;
  logic [PRIO_W-1:0]  setup_p;
  logic               emit;
  logic [1:0]         emit_kind;
  logic [TASK_W-1:0]  emit_task;
  logic               emit_last;

  prts_rdy_set u_rdy (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (rdy_cmd),
    .qa       (scan_t),
    .qb       (best_r),
    .rdy      (rdy),
    .before_q (before_q)
  );

  always_comb begin
    in_acc      = in_valid && (state_r == S_IDLE);
    tid_ok      = {1'b0, in_task_id} < CNT_W'(TASK_SLOTS);
    out_free    = !out_valid_r || !out_stall;
    dw_t        = dorder_r[idx_r[TASK_W-1:0]];
    dw_rem      = drem_r[dw_t] - DLY_W'(1);
    dw_end      = (idx_r == cnt_r);
    dw_exp      = (dw_rem == '0);
    dw_go       = !dw_end && (!(dw_exp && wait_r[dw_t]) || out_free);
    scan_t      = idx_r[TASK_W-1:0];
    scan_better = rdy[scan_t] && (!best_ok_r || (tprio_r[scan_t] < bprio_r) ||
                  ((tprio_r[scan_t] == bprio_r) && before_q));
    sw_need     = best_ok_r && (!cur_ok_r || (best_r != cur_r));
    rot_slice   = slice_r[cur_r] - 8'd1;
    unlock_nxt  = (lock_r != 8'd0) ? (lock_r - 8'd1) : lock_r;

    setup_t  = (state_r == S_IDLE) ? in_task_id : tid_r;
    setup_p  = (state_r == S_IDLE) ? in_task_prio : prio_r;
    if (32'(setup_p) >= PRIO_LEVELS) setup_p = PRIO_W'(PRIO_LEVELS - 1);
    do_setup = (in_acc && (in_action == ACT_SETUP) && tid_ok && !dly_r[in_task_id]) ||
               ((state_r == S_DRM) && dw_end && (act_r == ACT_SETUP));

    rdy_cmd.op      = RDY_NONE;
    rdy_cmd.task_id = in_task_id;
    if (do_setup) begin
      rdy_cmd.op      = RDY_HEAD_FORCE;
      rdy_cmd.task_id = setup_t;
    end else if (in_acc && tid_ok && (in_action == ACT_READY)) begin
      rdy_cmd.op = RDY_HEAD_IF_ABSENT;
    end else if (in_acc && tid_ok && (in_action == ACT_UNREADY)) begin
      rdy_cmd.op = RDY_REMOVE;
    end else if ((state_r == S_DWALK) && dw_go && dw_exp) begin
      rdy_cmd.op      = RDY_HEAD_IF_ABSENT;
      rdy_cmd.task_id = dw_t;
    end else if ((state_r == S_ROT) && cur_ok_r && (rot_slice == 8'd0)) begin
      rdy_cmd.op      = RDY_TAIL_IF_PRESENT;
      rdy_cmd.task_id = cur_r;
    end

    emit      = 1'b0;
    emit_kind = KIND_DONE;
    emit_task = cur_r;
    emit_last = 1'b0;
    case (state_r)
      S_DWALK: begin
        if (dw_go && dw_exp && wait_r[dw_t]) begin
          emit      = 1'b1;
          emit_kind = KIND_TMO;
          emit_task = dw_t;
        end
      end
      S_SWITCH: begin
        if (sw_need && out_free) begin
          emit      = 1'b1;
          emit_kind = KIND_SWITCH;
          emit_task = best_r;
        end
      end
      S_DONE: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dly_r       <= '0;
      wait_r      <= '0;
      dlen_r      <= '0;
      cur_r       <= '0;
      cur_ok_r    <= 1'b0;
      lock_r      <= '0;
      slen_r      <= SLICE_RST;
      out_valid_r <= 1'b0;
      best_ok_r   <= 1'b0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        tprio_r[i] <= PRIO_W'(PRIO_LEVELS - 1);
        drem_r[i]  <= '0;
        slice_r[i] <= SLICE_RST;
      end
    end else begin
      if (cfg_wr_en) slen_r <= cfg_wr_data;

      if (emit) begin
        out_valid_r <= 1'b1;
        out_kind_r  <= emit_kind;
        out_task_r  <= emit_task;
        out_lock_r  <= lock_r;
        out_last_r  <= emit_last;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (do_setup) begin
        tprio_r[setup_t] <= setup_p;
        drem_r[setup_t]  <= '0;
        dly_r[setup_t]   <= 1'b0;
        wait_r[setup_t]  <= 1'b0;
        slice_r[setup_t] <= slen_r;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            act_r     <= in_action;
            tid_r     <= in_task_id;
            prio_r    <= in_task_prio;
            idx_r     <= '0;
            wr_r      <= '0;
            cnt_r     <= dlen_r;
            best_ok_r <= 1'b0;
            case (in_action)
              ACT_TICK: state_r <= S_DWALK;
              ACT_DELAY: begin
                state_r <= S_DONE;
                if (tid_ok) begin
                  drem_r[in_task_id] <= in_ticks;
                  if (!dly_r[in_task_id] && (dlen_r < CNT_W'(TASK_SLOTS))) begin
                    dorder_r[dlen_r[TASK_W-1:0]] <= in_task_id;
                    dlen_r <= dlen_r + CNT_W'(1);
                    dly_r[in_task_id] <= 1'b1;
                  end
                end
              end
              ACT_WAKE, ACT_SETUP: begin
                state_r <= (tid_ok && dly_r[in_task_id]) ? S_DRM : S_DONE;
              end
              ACT_LOCK: begin
                state_r <= S_DONE;
                if (lock_r <= LOCK_MAX) lock_r <= lock_r + 8'd1;
              end
              ACT_UNLOCK: begin
                lock_r  <= unlock_nxt;
                state_r <= (unlock_nxt == 8'd0) ? S_SCAN : S_DONE;
              end
              ACT_SCHED: begin
                state_r <= (lock_r == 8'd0) ? S_SCAN : S_DONE;
              end
              ACT_WAIT: begin
                state_r <= S_DONE;
                if (tid_ok) wait_r[in_task_id] <= in_wait_flag;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_DWALK: begin
          if (dw_end) begin
            dlen_r  <= wr_r;
            state_r <= S_ROT;
          end else if (dw_go) begin
            drem_r[dw_t] <= dw_rem;
            if (dw_exp) begin
              wait_r[dw_t] <= 1'b0;
              dly_r[dw_t]  <= 1'b0;
            end else begin
              dorder_r[wr_r[TASK_W-1:0]] <= dw_t;
              wr_r <= wr_r + CNT_W'(1);
            end
            idx_r <= idx_r + CNT_W'(1);
          end
        end
        S_DRM: begin
          // compact the delay list, dropping the addressed task
          if (dw_end) begin
            dlen_r <= wr_r;
            if (act_r != ACT_SETUP) dly_r[tid_r] <= 1'b0;
            state_r <= S_DONE;
          end else begin
            if (dw_t != tid_r) begin
              dorder_r[wr_r[TASK_W-1:0]] <= dw_t;
              wr_r <= wr_r + CNT_W'(1);
            end
            idx_r <= idx_r + CNT_W'(1);
          end
        end
        S_ROT: begin
          if (cur_ok_r) begin
            slice_r[cur_r] <= (rot_slice == 8'd0) ? slen_r : rot_slice;
          end
          idx_r     <= '0;
          best_ok_r <= 1'b0;
          state_r   <= (lock_r == 8'd0) ? S_SCAN : S_DONE;
        end
        S_SCAN: begin
          if (idx_r == CNT_W'(TASK_SLOTS)) begin
            state_r <= S_SWITCH;
          end else begin
            if (scan_better) begin
              best_r    <= scan_t;
              bprio_r   <= tprio_r[scan_t];
              best_ok_r <= 1'b1;
            end
            idx_r <= idx_r + CNT_W'(1);
          end
        end
        S_SWITCH: begin
          if (!sw_need) begin
            state_r <= S_DONE;
          end else if (out_free) begin
            cur_r    <= best_r;
            cur_ok_r <= 1'b1;
            state_r  <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_task_ref   = out_task_r;
  assign out_lock_level = out_lock_r;
  assign out_last       = out_last_r;

  `PRTS_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `PRTS_ASSERT_IMP(a_last_is_done, out_valid && out_last, out_kind == KIND_DONE)
  `PRTS_ASSERT_IMP(a_scan_unlocked, state_r == S_SCAN, lock_r == 8'd0)
  `PRTS_ASSERT_NXT(a_switch_sets_cur, emit && (emit_kind == KIND_SWITCH), cur_ok_r)
endmodule
`default_nettype wire

// ===== design/prts_rdy_set.sv =====
// Ready set: membership bits plus a pairwise precedence matrix giving list order.
`default_nettype none
module prts_rdy_set (
  input  wire                           clk,
  input  wire                           rst_n,
  input  prts_pkg::rdy_cmd_t            cmd,
  input  wire  [prts_pkg::TASK_W-1:0]   qa,
  input  wire  [prts_pkg::TASK_W-1:0]   qb,
  output logic [prts_pkg::TASK_SLOTS-1:0] rdy,
  output logic                          before_q
);
  import prts_pkg::*;

  logic [TASK_SLOTS-1:0] rdy_r;
  // mat_r[a][b] set: a stands ahead of b in its list
  logic [TASK_SLOTS-1:0] mat_r [TASK_SLOTS];
  logic                  to_head;
  logic                  to_tail;

  always_comb begin
    to_head = 1'b0;
    to_tail = 1'b0;
    case (cmd.op)
      RDY_HEAD_IF_ABSENT:  to_head = !rdy_r[cmd.task_id];
      RDY_HEAD_FORCE:      to_head = 1'b1;
      RDY_TAIL_IF_PRESENT: to_tail = rdy_r[cmd.task_id];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdy_r <= '0;
    end else begin
      if (to_head) rdy_r[cmd.task_id] <= 1'b1;
      if (cmd.op == RDY_REMOVE) rdy_r[cmd.task_id] <= 1'b0;
    end
    for (int j = 0; j < TASK_SLOTS; j++) begin
      if (j != int'(cmd.task_id)) begin
        if (to_head) begin
          mat_r[cmd.task_id][j] <= 1'b1;
          mat_r[j][cmd.task_id] <= 1'b0;
        end else if (to_tail) begin
          mat_r[cmd.task_id][j] <= 1'b0;
          mat_r[j][cmd.task_id] <= 1'b1;
        end
      end
    end
  end

  assign rdy      = rdy_r;
  assign before_q = mat_r[qa][qb];
endmodule
`default_nettype wire
